>>> hw/rtl/kdr_pkg.sv
`timescale 1ns / 1ps

package kdr_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int KEY_BYTES_DEF = 20;
    localparam int KEY_MAX       = 20;
    localparam int KEY_W         = 8 * KEY_MAX;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_LOOKUP     = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    localparam logic [31:0] INV_EP_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] hi;
        logic [63:0] mid;
        logic [63:0] lo;
    } key_t;

    typedef struct packed {
        logic [31:0] endpoint;
        logic [31:0] server_id;
        logic [15:0] dev_class;
        logic [7:0]  dev_instance;
    } payload_t;

    typedef struct packed {
        key_t     key;
        payload_t data;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0] cmd;
        key_t       key;
        logic       key_valid;
        payload_t   data;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        payload_t   data;
    } result_t;

endpackage

>>> hw/rtl/kdr_ram.sv
`timescale 1ns / 1ps

module kdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/kdr_key_canon.sv
`timescale 1ns / 1ps

module kdr_key_canon #(
    parameter int KEY_BYTES = kdr_pkg::KEY_BYTES_DEF
) (
    input  logic [63:0]   key_lo,
    input  logic [63:0]   key_mid,
    input  logic [31:0]   key_hi,
    output kdr_pkg::key_t key,
    output logic          key_valid
);

    import kdr_pkg::*;

    logic [KEY_W-1:0]   raw;
    logic [KEY_W-1:0]   canon;
    logic [KEY_MAX-1:0] zero;

    assign raw = {key_hi, key_mid, key_lo};

    // a byte survives only if no NUL sits below it within the key window
    always_comb
    begin
        logic pre;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            zero[i] = (i < KEY_BYTES) && (raw[8*i +: 8] == CHAR_NUL);
        end
        for (int i = 0; i < KEY_MAX; i++)
        begin
            pre = 1'b0;
            for (int j = 0; j < KEY_MAX; j++)
            begin
                if (j < i)
                begin
                    pre = pre | zero[j];
                end
            end
            canon[8*i +: 8] = ((i < KEY_BYTES) && !pre) ? raw[8*i +: 8] : CHAR_NUL;
        end
    end

    // byte 0 nonzero and byte 1 nonzero puts the first NUL at index 2 or later
    assign key_valid = (raw[7:0] == CHAR_SLASH) && (raw[15:8] != CHAR_NUL)
                       && (|zero[KEY_MAX-1:2]);

    assign key = canon;

endmodule

>>> hw/rtl/kdr_ctrl.sv
`timescale 1ns / 1ps

module kdr_ctrl #(
    parameter int ENTRIES = kdr_pkg::ENTRIES_DEF,
    parameter int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  kdr_pkg::req_t            req,
    input  logic [31:0]              inv_endpoint,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output kdr_pkg::result_t         result,
    output logic                     ram_we,
    output logic [IDX_W-1:0]         ram_waddr,
    output logic [kdr_pkg::ENTRY_W-1:0] ram_wdata,
    output logic                     ram_re,
    output logic [IDX_W-1:0]         ram_raddr,
    input  logic [kdr_pkg::ENTRY_W-1:0] ram_rdata
);

    import kdr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE,
        ST_PUSH
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t             state_reg;
    req_t               req_reg;
    logic [ENTRIES-1:0] used_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    payload_t           hit_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    result_t            pend_reg;
    result_t            res_reg;
    logic               m_valid_reg;

    entry_t  rd_entry;
    logic    cmp_used;
    logic    key_hit;
    logic    accept;
    logic    push;
    logic    reg_ok;
    logic    unreg_ok;
    result_t res_next;

    assign rd_entry = ram_rdata;
    assign cmp_used = used_reg[cmp_idx_reg];
    assign key_hit  = cmp_vld_reg && cmp_used && (rd_entry.key == req_reg.key);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign push     = (state_reg == ST_PUSH) && (!m_valid_reg || m_tready);

    assign reg_ok   = req_reg.key_valid && (req_reg.cmd == CMD_REGISTER)
                      && (req_reg.data.endpoint != inv_endpoint)
                      && !found_reg && free_found_reg;
    assign unreg_ok = req_reg.key_valid && (req_reg.cmd == CMD_UNREGISTER) && found_reg;

    // reads only happen in SCAN and the write only in DONE, so no read ever
    // overlaps a pending write to the same entry
    assign ram_re    = (state_reg == ST_SCAN);
    assign ram_raddr = rd_idx_reg;
    assign ram_we    = (state_reg == ST_DONE) && reg_ok;
    assign ram_waddr = free_idx_reg;
    assign ram_wdata = {req_reg.key, req_reg.data};

    always_comb
    begin
        res_next        = '0;
        res_next.status = STAT_INVALID;
        if (req_reg.key_valid)
        begin
            case (req_reg.cmd)
                CMD_REGISTER:
                begin
                    if (req_reg.data.endpoint == inv_endpoint || found_reg)
                    begin
                        res_next.status = STAT_INVALID;
                    end
                    else if (!free_found_reg)
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        res_next.status = STAT_OK;
                    end
                end
                CMD_UNREGISTER:
                begin
                    res_next.status = found_reg ? STAT_OK : STAT_NOTFOUND;
                end
                CMD_LOOKUP:
                begin
                    if (found_reg)
                    begin
                        res_next.status = STAT_OK;
                        res_next.data   = hit_reg;
                    end
                    else
                    begin
                        res_next.status = STAT_NOTFOUND;
                    end
                end
                default:
                begin
                    res_next.status = STAT_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            rd_idx_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                m_valid_reg <= 1'b1;
                res_reg     <= pend_reg;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            cmp_vld_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg <= rd_idx_reg;

            if (key_hit)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= cmp_idx_reg;
                hit_reg       <= rd_entry.data;
            end
            if (cmp_vld_reg && !cmp_used && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg        <= req;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        rd_idx_reg     <= '0;
                        state_reg      <= req.key_valid ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN:
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    pend_reg <= res_next;
                    if (reg_ok)
                    begin
                        used_reg[free_idx_reg] <= 1'b1;
                    end
                    if (unreg_ok)
                    begin
                        used_reg[found_idx_reg] <= 1'b0;
                    end
                    state_reg <= ST_PUSH;
                end
                ST_PUSH:
                begin
                    if (push)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign result   = res_reg;

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("compare stage active outside scan");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !used_reg[free_idx_reg])
        else $error("register overwrites a used entry");

    a_reg_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && reg_ok) |=>
        ($countones(used_reg) == $past($countones(used_reg)) + 1))
        else $error("used count did not grow on register");

    a_unreg_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && unreg_ok) |=>
        ($countones(used_reg) + 1 == $past($countones(used_reg))))
        else $error("used count did not shrink on unregister");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && res_reg.status != STAT_OK) |-> (res_reg.data == '0))
        else $error("nonzero data on failed transaction");

endmodule

>>> hw/rtl/keyed_device_registry_table_core.sv
`timescale 1ns / 1ps
// A valid key is handled by one RAM read per entry, then compare drain, decide/write
// and output load, the last of which waits while the output is full and m_tready is low;
// an invalid key skips the scan and drain. One transaction in flight: s_tready is high
// only while idle, so a new transaction is taken only after the last result is loaded.
// Reset clears all used bits and loads invalid_endpoint with 0xFFFFFFFF; the entry
// RAM itself is not cleared and needs no clearing pass.

module keyed_device_registry_table_core #(
    parameter int ENTRIES   = kdr_pkg::ENTRIES_DEF,
    parameter int KEY_BYTES = kdr_pkg::KEY_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd, key_lo, key_mid, key_hi, endpoint, server_id, dev_class, dev_instance
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, out_endpoint, out_server_id, out_class, out_instance
    output logic [95:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    import kdr_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [31:0]        inv_ep_reg;
    key_t               canon_key;
    logic               key_valid;
    req_t               req;
    result_t            result;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_ep_reg <= INV_EP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            inv_ep_reg <= cfg_data;
        end
    end

    kdr_key_canon #(
        .KEY_BYTES(KEY_BYTES)
    ) u_canon (
        .key_lo   (s_tdata[65:2]),
        .key_mid  (s_tdata[129:66]),
        .key_hi   (s_tdata[161:130]),
        .key      (canon_key),
        .key_valid(key_valid)
    );

    assign req.cmd               = s_tdata[1:0];
    assign req.key               = canon_key;
    assign req.key_valid         = key_valid;
    assign req.data.endpoint     = s_tdata[193:162];
    assign req.data.server_id    = s_tdata[225:194];
    assign req.data.dev_class    = s_tdata[241:226];
    assign req.data.dev_instance = s_tdata[249:242];

    kdr_ctrl #(
        .ENTRIES(ENTRIES),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req         (req),
        .inv_endpoint(inv_ep_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .result      (result),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    kdr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES),
        .ADDR_W(IDX_W)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign m_tdata = {6'd0, result.data.dev_instance, result.data.dev_class,
                      result.data.server_id, result.data.endpoint, result.status};

endmodule
